### design/pns_pkg.sv
package pns_pkg;

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_READ  = 1'b1
	} op_t;

	localparam int unsigned BASES_PER_WORD = 16;
	localparam logic [4:0]  MAX_COUNT      = 5'd16;
	localparam logic [1:0]  CODE_A         = 2'b00;
	localparam logic [1:0]  CODE_C         = 2'b01;
	localparam logic [1:0]  CODE_G         = 2'b10;
	localparam logic [1:0]  CODE_T         = 2'b11;

	typedef struct packed {
		op_t         opcode;
		logic [13:0] position;
		logic [7:0]  base_char;
		logic [1:0]  fill_code;
		logic [4:0]  read_count;
	} req_t;

	// ascii letter to 2-bit code, either case
	function automatic logic [1:0] letter_code(input logic [7:0] ch, input logic [1:0] fill);
		logic [1:0] code;
		case (ch)
			8'h41, 8'h61: code = CODE_A;
			8'h43, 8'h63: code = CODE_C;
			8'h47, 8'h67: code = CODE_G;
			8'h54, 8'h74: code = CODE_T;
			default:      code = fill;
		endcase
		return code;
	endfunction

endpackage

### design/packed_nucleotide_store.sv
// Packed store of DNA bases, two bits each and sixteen to a 32-bit word, first base in the top
// bits. A write request puts one ASCII letter at a base position (A/C/G/T in either case give
// codes 0..3, anything else stores fill_code) and gives no response; a read request returns
// read_count codes (saturated at 16) right-aligned in kmer, with bases at or past
// length_words*16 reading as zero. One request is taken per cycle, reads and writes freely
// mixed: the words sit in an even and an odd bank of synchronous RAM, so a read gets
// both words its run can span in the same cycle, and a write merges its base in the
// cycle after acceptance and writes the word back, with the last write forwarded to a
// following request. A read response is registered: a read passes stage one, where the
// bank words arrive, then the response register; only a stalled response slows intake.
// Memory contents are undefined after reset until written; there is no clearing pass.
module packed_nucleotide_store import pns_pkg::*; #(
	parameter int unsigned WORDS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [10:0] cfg_wr_data,
	input  logic        req_valid,
	output logic        req_ready,
	input  logic        opcode,
	input  logic [13:0] position,
	input  logic [7:0]  base_char,
	input  logic [1:0]  fill_code,
	input  logic [4:0]  read_count,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output logic [31:0] kmer
);

	// position reaches at most 1024 words
	localparam int unsigned DEPTH  = (WORDS < 1024) ? WORDS : 1024;
	localparam int unsigned BDEPTH = (DEPTH + 1) / 2;
	localparam int unsigned BAW    = (BDEPTH > 1) ? $clog2(BDEPTH) : 1;

	logic [10:0]    length_q;
	logic           s1_valid_q;
	req_t           req_s1;
	logic [BAW-1:0] addr_e_s1;
	logic [BAW-1:0] addr_o_s1;
	logic           lw_valid_q;
	logic           lw_bank_q;
	logic [BAW-1:0] lw_addr_q;
	logic [31:0]    lw_data_q;
	logic           rsp_valid_q;
	logic [31:0]    kmer_q;

	req_t           req_in;
	logic           accept;
	logic           s1_adv;
	logic           rsp_load;
	logic [9:0]     w_in;
	logic [BAW-1:0] rd_addr_e;
	logic [BAW-1:0] rd_addr_o;
	logic [31:0]    rdata_e;
	logic [31:0]    rdata_o;
	logic [31:0]    word_e;
	logic [31:0]    word_o;
	logic [9:0]     w_s1;
	logic [10:0]    eff_len;
	logic           w_in_len;
	logic           w1_in_len;
	logic [31:0]    word_hi;
	logic [31:0]    word_lo;
	logic [31:0]    kmer_d;
	logic           wr_en;
	logic [BAW-1:0] wr_addr;
	logic [31:0]    wr_data;
	logic [4:0]     bit_sh;
	logic [31:0]    mask;

	assign req_in = '{opcode: op_t'(opcode), position: position, base_char: base_char,
		fill_code: fill_code, read_count: read_count};

	assign accept    = req_valid && req_ready;
	assign w_in      = position[13:4];
	assign rd_addr_e = w_in[0] ? BAW'({1'b0, w_in[9:1]} + 10'd1) : BAW'(w_in[9:1]);
	assign rd_addr_o = BAW'(w_in[9:1]);

	assign rsp_load  = s1_valid_q && (req_s1.opcode == OP_READ);
	assign s1_adv    = s1_valid_q && (req_s1.opcode == OP_WRITE || !rsp_valid_q || rsp_ready);
	assign req_ready = !s1_valid_q || s1_adv;

	pns_bank #(.DEPTH(BDEPTH), .AW(BAW)) u_bank_even (
		.clk     (clk),
		.wr_en   (wr_en && !w_s1[0]),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (accept),
		.rd_addr (rd_addr_e),
		.rd_data (rdata_e)
	);

	pns_bank #(.DEPTH(BDEPTH), .AW(BAW)) u_bank_odd (
		.clk     (clk),
		.wr_en   (wr_en && w_s1[0]),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (accept),
		.rd_addr (rd_addr_o),
		.rd_data (rdata_o)
	);

	// forward the last write; it may have landed on the same edge as this read
	always_comb begin
		w_s1   = req_s1.position[13:4];
		word_e = (lw_valid_q && !lw_bank_q && lw_addr_q == addr_e_s1) ? lw_data_q : rdata_e;
		word_o = (lw_valid_q && lw_bank_q && lw_addr_q == addr_o_s1) ? lw_data_q : rdata_o;

		eff_len   = ({21'd0, length_q} > 32'(WORDS)) ? 11'(WORDS) : length_q;
		w_in_len  = {1'b0, w_s1} < eff_len;
		w1_in_len = ({1'b0, w_s1} + 11'd1) < eff_len;
		word_hi   = w_s1[0] ? word_o : word_e;
		word_lo   = w1_in_len ? (w_s1[0] ? word_e : word_o) : 32'd0;

		bit_sh  = {~req_s1.position[3:0], 1'b0};
		mask    = 32'd3 << bit_sh;
		wr_data = (word_hi & ~mask)
			| ({30'd0, letter_code(req_s1.base_char, req_s1.fill_code)} << bit_sh);
		wr_addr = BAW'(w_s1[9:1]);
		wr_en   = s1_adv && (req_s1.opcode == OP_WRITE) && ({22'd0, w_s1} < 32'(WORDS));
	end

	pns_kmer u_kmer (
		.word_hi    (word_hi),
		.word_lo    (word_lo),
		.offset     (req_s1.position[3:0]),
		.read_count (req_s1.read_count),
		.in_range   (w_in_len),
		.kmer       (kmer_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q    <= '0;
			s1_valid_q  <= 1'b0;
			lw_valid_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				length_q <= cfg_wr_data;
			end
			if (req_ready) begin
				s1_valid_q <= accept;
			end
			if (wr_en) begin
				lw_valid_q <= 1'b1;
			end
			if (rsp_load && s1_adv) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1    <= req_in;
			addr_e_s1 <= rd_addr_e;
			addr_o_s1 <= rd_addr_o;
		end
		if (wr_en) begin
			lw_bank_q <= w_s1[0];
			lw_addr_q <= wr_addr;
			lw_data_q <= wr_data;
		end
		if (rsp_load && s1_adv) begin
			kmer_q <= kmer_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign kmer      = kmer_q;

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> (s1_valid_q && rsp_valid_q && req_s1.opcode == OP_READ))
		else $error("intake stalled without a blocked read");

	a_write_source: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (s1_valid_q && req_s1.opcode == OP_WRITE))
		else $error("memory write without a write request in stage one");

	a_rsp_from_read: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(rsp_load && s1_adv))
		else $error("response raised without a read");

	a_out_of_range: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_load && s1_adv && !w_in_len) |=> (kmer_q == 32'd0))
		else $error("read past the length returned nonzero bases");

endmodule

### design/pns_bank.sv
module pns_bank #(
	parameter int unsigned DEPTH = 512,
	parameter int unsigned AW    = 9
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [31:0]   wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [31:0]   rd_data
);

	logic [31:0] mem [0:DEPTH-1];
	logic [31:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read returns the old contents on a same-cycle write
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### design/pns_kmer.sv
module pns_kmer import pns_pkg::*; (
	input  logic [31:0] word_hi,
	input  logic [31:0] word_lo,
	input  logic [3:0]  offset,
	input  logic [4:0]  read_count,
	input  logic        in_range,
	output logic [31:0] kmer
);

	logic [63:0] pair;
	logic [63:0] aligned;
	logic [31:0] window;
	logic [4:0]  count;
	logic [5:0]  rshift;

	always_comb begin
		pair    = {word_hi, word_lo};
		aligned = pair << {offset, 1'b0};
		window  = aligned[63:32];
		count   = (read_count > MAX_COUNT) ? MAX_COUNT : read_count;
		// a zero count shifts by the full width and yields zero
		rshift  = {MAX_COUNT - count, 1'b0};
		kmer    = in_range ? (window >> rshift) : 32'd0;
	end

endmodule
